[design/dqc_pkg.sv]
// Shared types and constants for the dual quadrature counter.
`timescale 1ns / 1ps
package dqc_pkg;

   // Width of each reported delta field
   localparam int DELTA_WIDTH = 16;

   // Number of encoders handled side by side
   localparam int LANE_COUNT = 2;

   // Pin levels carried per encoder (channel 1, channel 2)
   localparam int LEVELS_PER_LANE = 2;

   // Item kinds carried on req_tuser
   localparam logic ACTION_SAMPLE   = 1'b0;
   localparam logic ACTION_SNAPSHOT = 1'b1;

   // Per-transfer control sent from the top level to every lane
   typedef struct packed {
      logic sample;  // pin level sample accepted
      logic clear;   // snapshot accepted: clear the count
   } lane_ctrl_type;

endpackage

[design/dqc_lane.sv]
// One encoder lane: edge detection and saturating 2x up/down count.
`timescale 1ns / 1ps
module dqc_lane #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dqc_pkg::lane_ctrl_type        ctrl,
   input  logic [1:0]                    levels,   // [0] ch1, [1] ch2
   output logic signed [COUNT_WIDTH-1:0] count
);
   import dqc_pkg::*;

   localparam logic signed [COUNT_WIDTH-1:0] CountMax = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
   localparam logic signed [COUNT_WIDTH-1:0] CountMin = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

   logic signed [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [1:0]                    prior_ff, prior_in;
   logic                          known_ff, known_in;
   logic                          rise1;
   logic                          rise2;
   logic                          step_up;
   logic                          step_down;

   // Rising edges against the previous sample
   assign rise1 = levels[0] & ~prior_ff[0];
   assign rise2 = levels[1] & ~prior_ff[1];

   // Channel 1 edge takes priority over channel 2
   always_comb begin
      step_up   = 1'b0;
      step_down = 1'b0;
      if (known_ff) begin
         if (rise1) begin
            step_up   = levels[1];
            step_down = ~levels[1];
         end else if (rise2) begin
            step_up   = ~levels[0];
            step_down = levels[0];
         end
      end
   end

   // Next state of count, prior levels and first-sample flag
   always_comb begin
      count_in = count_ff;
      prior_in = prior_ff;
      known_in = known_ff;
      if (ctrl.clear) begin
         count_in = '0;
      end else if (ctrl.sample) begin
         if (step_up && count_ff != CountMax) begin
            count_in = count_ff + COUNT_WIDTH'(1);
         end else if (step_down && count_ff != CountMin) begin
            count_in = count_ff - COUNT_WIDTH'(1);
         end
         prior_in = levels;
         known_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         prior_ff <= '0;
         known_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         prior_ff <= prior_in;
         known_ff <= known_in;
      end
   end

   assign count = count_ff;

endmodule

[design/dqc_merge.sv]
// Merge stage: saturates lane counts into one result and buffers it for output.
`timescale 1ns / 1ps
module dqc_merge #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  logic signed [COUNT_WIDTH-1:0]   left_count,
   input  logic signed [COUNT_WIDTH-1:0]   right_count,
   output logic                            skid_full,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [2*dqc_pkg::DELTA_WIDTH-1:0] rsp_tdata
);
   import dqc_pkg::*;

   localparam int WideWidth = 33;
   localparam logic signed [COUNT_WIDTH-1:0] CountMax = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
   localparam logic signed [COUNT_WIDTH-1:0] CountMin = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
   localparam logic signed [WideWidth-1:0] DeltaMax = WideWidth'(32767);
   localparam logic signed [WideWidth-1:0] DeltaMin = -WideWidth'(32768);

   logic signed [COUNT_WIDTH-1:0] right_neg;
   logic signed [WideWidth-1:0]   left_wide;
   logic signed [WideWidth-1:0]   right_wide;
   logic [DELTA_WIDTH-1:0]        left_delta;
   logic [DELTA_WIDTH-1:0]        right_delta;
   logic [2*DELTA_WIDTH-1:0]      result;

   logic                     out_valid_ff, out_valid_in;
   logic [2*DELTA_WIDTH-1:0] out_data_ff, out_data_in;
   logic                     skid_valid_ff, skid_valid_in;
   logic [2*DELTA_WIDTH-1:0] skid_data_ff, skid_data_in;
   logic                     pop;

   // Saturating negation of the second count
   assign right_neg = (right_count == CountMin) ? CountMax : -right_count;

   // Sign extend, then clamp to the 16-bit result range
   assign left_wide  = {{(WideWidth-COUNT_WIDTH){left_count[COUNT_WIDTH-1]}}, left_count};
   assign right_wide = {{(WideWidth-COUNT_WIDTH){right_neg[COUNT_WIDTH-1]}}, right_neg};

   always_comb begin
      if (left_wide > DeltaMax) begin
         left_delta = DeltaMax[DELTA_WIDTH-1:0];
      end else if (left_wide < DeltaMin) begin
         left_delta = DeltaMin[DELTA_WIDTH-1:0];
      end else begin
         left_delta = left_wide[DELTA_WIDTH-1:0];
      end
      if (right_wide > DeltaMax) begin
         right_delta = DeltaMax[DELTA_WIDTH-1:0];
      end else if (right_wide < DeltaMin) begin
         right_delta = DeltaMin[DELTA_WIDTH-1:0];
      end else begin
         right_delta = right_wide[DELTA_WIDTH-1:0];
      end
   end

   assign result = {right_delta, left_delta};
   assign pop    = out_valid_ff & rsp_tready;

   // Output register with one skid entry behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign skid_full  = skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

[design/dual_quadrature_counter_2x.sv]
// Top level of the dual quadrature counter: two encoder lanes and the merge stage.
`timescale 1ns / 1ps
// Dual 2x quadrature counter. Each req transfer is either a pin level sample
// (req_tuser low) or a snapshot (req_tuser high). One sample can be accepted
// every cycle while req_tready is high; both encoder lanes update their counts in
// the same cycle the sample is accepted. A snapshot returns the left count and
// the negated right count, both clamped to 16 bits, as a registered result on rsp, and
// clears the counts. Results pass through an output register plus one skid
// entry, so req_tready only drops while both hold results that the consumer
// has not taken. The first sample after reset only records pin levels.
module dual_quadrature_counter_2x #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] left_ch1_level, [1] left_ch2_level,
                                    // [2] right_ch1_level, [3] right_ch2_level, [7:4] zero
   input  logic        req_tuser,   // [0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [15:0] left_delta, [31:16] right_delta
);
   import dqc_pkg::*;

   logic                          accept;
   logic                          skid_full;
   lane_ctrl_type                 ctrl;
   logic signed [COUNT_WIDTH-1:0] counts [LANE_COUNT];

   // Input handshake and per-transfer lane control
   assign req_tready = ~skid_full;
   assign accept     = req_tvalid & req_tready;
   assign ctrl.sample = accept && (req_tuser == ACTION_SAMPLE);
   assign ctrl.clear  = accept && (req_tuser == ACTION_SNAPSHOT);

   // One lane per encoder
   for (genvar i = 0; i < LANE_COUNT; i++) begin : g_lane
      dqc_lane #(
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (ctrl),
         .levels (req_tdata[LEVELS_PER_LANE*i +: LEVELS_PER_LANE]),
         .count  (counts[i])
      );
   end

   // Combine lane counts into the snapshot result
   dqc_merge #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .push        (ctrl.clear),
      .left_count  (counts[0]),
      .right_count (counts[1]),
      .skid_full   (skid_full),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

[tb/sv/tb_dual_quadrature_counter_2x.sv]
// Self-checking testbench for the dual 2x quadrature counter.
`timescale 1ns / 1ps
module tb_dual_quadrature_counter_2x;
   import dqc_pkg::*;

   localparam int     COUNT_W      = 16;
   localparam longint COUNT_HI     = (longint'(1) << (COUNT_W - 1)) - 1;
   localparam longint COUNT_LO     = -COUNT_HI - 1;
   localparam longint DELTA_HI     = (longint'(1) << (DELTA_WIDTH - 1)) - 1;
   localparam longint DELTA_LO     = -DELTA_HI - 1;
   localparam int     RANDOM_ITEMS = 1400;
   // single steps per one-direction run
   localparam int     SAT_STEPS    = 90;
   localparam int     ROW_COUNT    = 19;

   // one snapshot result, laid out as on rsp_tdata
   typedef struct packed {
      logic signed [DELTA_WIDTH-1:0] right;
      logic signed [DELTA_WIDTH-1:0] left;
   } delta_pair_type;

   // directed stimulus row; typed is used only when fixed is set
   typedef struct packed {
      logic           action;
      logic [3:0]     levels;  // {right ch2, right ch1, left ch2, left ch1}
      logic           fixed;
      delta_pair_type typed;
   } stim_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [0] left ch1, [1] left ch2, [2] right ch1, [3] right ch2
   logic        req_tuser  = ACTION_SAMPLE;   // [0] action
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [31:0] rsp_tdata;            // [15:0] left_delta, [31:16] right_delta

   // predictor state
   logic [3:0]     last_levels = 4'b0000;
   bit             levels_seen = 1'b0;
   longint         left_count  = 0;
   longint         right_count = 0;
   delta_pair_type expected_deltas[$];

   int          errors      = 0;
   int          sent_items  = 0;
   int          send_calm   = 0;
   int          recv_calm   = 0;

   // quadrature sequence as {ch2, ch1}; stepping up the index counts up
   logic [1:0]  gray_seq[4] = '{2'b00, 2'b10, 2'b11, 2'b01};

   stim_row_type directed_rows[ROW_COUNT] = '{
      '{ACTION_SNAPSHOT, 4'b0000, 1'b1, 32'd0},  // snapshot straight after reset
      '{ACTION_SAMPLE,   4'b1111, 1'b0, 32'd0},  // first sample only records levels
      '{ACTION_SNAPSHOT, 4'b0000, 1'b1, 32'd0},  // nothing counted yet
      '{ACTION_SAMPLE,   4'b0000, 1'b0, 32'd0},  // all fall
      '{ACTION_SAMPLE,   4'b0001, 1'b0, 32'd0},  // left ch1 rises, ch2 low
      '{ACTION_SAMPLE,   4'b0011, 1'b0, 32'd0},  // left ch2 rises, ch1 high
      '{ACTION_SAMPLE,   4'b0100, 1'b0, 32'd0},  // right ch1 rises, ch2 low
      '{ACTION_SAMPLE,   4'b1100, 1'b0, 32'd0},  // right ch2 rises, ch1 high
      '{ACTION_SNAPSHOT, 4'b0000, 1'b0, 32'd0},
      '{ACTION_SAMPLE,   4'b0000, 1'b0, 32'd0},
      '{ACTION_SAMPLE,   4'b1111, 1'b0, 32'd0},  // both channels rise together
      '{ACTION_SAMPLE,   4'b0000, 1'b0, 32'd0},
      '{ACTION_SAMPLE,   4'b0010, 1'b0, 32'd0},  // left ch2 rises, ch1 low
      '{ACTION_SAMPLE,   4'b1000, 1'b0, 32'd0},  // right ch2 rises, ch1 low
      '{ACTION_SAMPLE,   4'b1010, 1'b0, 32'd0},
      '{ACTION_SNAPSHOT, 4'b1111, 1'b0, 32'd0},  // levels ignored on snapshot
      '{ACTION_SAMPLE,   4'b0101, 1'b0, 32'd0},  // edges against levels before snapshot
      '{ACTION_SNAPSHOT, 4'b0000, 1'b0, 32'd0},
      '{ACTION_SNAPSHOT, 4'b0000, 1'b1, 32'd0}   // counts were cleared
   };

   dual_quadrature_counter_2x #(
      .COUNT_WIDTH(COUNT_W)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   function automatic longint clamp(longint v, longint lo, longint hi);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // 2x decode of one encoder: cur/prev are {ch2, ch1}
   function automatic longint count_step(longint cnt, logic [1:0] cur, logic [1:0] prev);
      if (cur[0] && !prev[0])
         return clamp(cur[1] ? cnt + 1 : cnt - 1, COUNT_LO, COUNT_HI);
      if (cur[1] && !prev[1])
         return clamp(cur[0] ? cnt - 1 : cnt + 1, COUNT_LO, COUNT_HI);
      return cnt;
   endfunction

   function automatic int gray_pos(logic [1:0] v);
      for (int i = 0; i < 4; i++)
         if (gray_seq[i] == v) return i;
      return 0;
   endfunction

   // per-transfer wait, with occasional stretches of no idling
   task automatic draw_wait(inout int calm, output int gap);
      if (calm > 0) begin
         gap = 0;
         calm--;
      end else begin
         gap = $urandom_range(0, 4);
         if ($urandom_range(0, 15) == 0) calm = $urandom_range(5, 40);
      end
   endtask

   // drive one req transfer and update the predictor once it is accepted
   task automatic send_item(input logic action, input logic [3:0] lv,
                            input logic fixed = 1'b0, input delta_pair_type typed = '0);
      int             gap;
      delta_pair_type d;
      draw_wait(send_calm, gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {4'b0000, lv};
      do @(posedge clock); while (req_tready !== 1'b1);
      sent_items++;
      if (action == ACTION_SNAPSHOT) begin
         d.left  = DELTA_WIDTH'(clamp(left_count, DELTA_LO, DELTA_HI));
         d.right = DELTA_WIDTH'(clamp(-right_count, DELTA_LO, DELTA_HI));
         if (fixed) d = typed;
         expected_deltas.push_back(d);
         left_count  = 0;
         right_count = 0;
      end else begin
         if (levels_seen) begin
            left_count  = count_step(left_count, lv[1:0], last_levels[1:0]);
            right_count = count_step(right_count, lv[3:2], last_levels[3:2]);
         end
         last_levels = lv;
         levels_seen = 1'b1;
      end
   endtask

   // result side: random stalls, compare each transfer with the oldest prediction
   initial begin
      int             gap;
      delta_pair_type want;
      logic signed [DELTA_WIDTH-1:0] got_left, got_right;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         draw_wait(recv_calm, gap);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            do @(posedge clock); while (rsp_tvalid !== 1'b1);
            repeat (gap - 1) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         got_left  = rsp_tdata[15:0];
         got_right = rsp_tdata[31:16];
         if (expected_deltas.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual left %0d right %0d",
                     $time, got_left, got_right);
         end else begin
            want = expected_deltas.pop_front();
            if (got_left !== want.left) begin
               errors++;
               $display("%0t: left_delta expected %0d, actual %0d",
                        $time, want.left, got_left);
            end
            if (got_right !== want.right) begin
               errors++;
               $display("%0t: right_delta expected %0d, actual %0d",
                        $time, want.right, got_right);
            end
         end
      end
   end

   // stimulus: directed rows, random walk with noise, then one-direction runs
   initial begin
      int         pos_l, pos_r, dir_l, dir_r, step, run_len;
      logic [3:0] lv;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < ROW_COUNT; i++)
         send_item(directed_rows[i].action, directed_rows[i].levels,
                   directed_rows[i].fixed, directed_rows[i].typed);

      pos_l = gray_pos(last_levels[1:0]);
      pos_r = gray_pos(last_levels[3:2]);
      while (sent_items < ROW_COUNT + RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               // noise: arbitrary levels, including double edges
               run_len = $urandom_range(1, 4);
               repeat (run_len) begin
                  lv = 4'($urandom);
                  send_item(ACTION_SAMPLE, lv);
               end
               pos_l = gray_pos(last_levels[1:0]);
               pos_r = gray_pos(last_levels[3:2]);
            end
            2: begin
               // back-to-back snapshots to fill the result buffer
               run_len = $urandom_range(1, 5);
               repeat (run_len) begin
                  lv = 4'($urandom);
                  send_item(ACTION_SNAPSHOT, lv);
               end
            end
            default: begin
               // well-formed rotation with occasional holds and reversals
               run_len = $urandom_range(1, 40);
               dir_l = $urandom_range(0, 1) ? 1 : -1;
               dir_r = $urandom_range(0, 1) ? 1 : -1;
               repeat (run_len) begin
                  step  = $urandom_range(0, 9);
                  pos_l = (pos_l + (step == 0 ? 0 : step == 1 ? -dir_l : dir_l) + 4) % 4;
                  step  = $urandom_range(0, 9);
                  pos_r = (pos_r + (step == 0 ? 0 : step == 1 ? -dir_r : dir_r) + 4) % 4;
                  send_item(ACTION_SAMPLE, {gray_seq[pos_r], gray_seq[pos_l]});
               end
               if ($urandom_range(0, 9) < 4) begin
                  lv = 4'($urandom);
                  send_item(ACTION_SNAPSHOT, lv);
               end
            end
         endcase
      end

      // steady runs in one direction, up then down
      for (int dir = 1; dir >= -1; dir -= 2) begin
         send_item(ACTION_SNAPSHOT, 4'b0000);
         repeat (SAT_STEPS) begin
            pos_l = (pos_l + dir + 4) % 4;
            pos_r = (pos_r + dir + 4) % 4;
            send_item(ACTION_SAMPLE, {gray_seq[pos_r], gray_seq[pos_l]});
         end
         send_item(ACTION_SNAPSHOT, 4'b1111);
      end

      req_tvalid <= 1'b0;
      while (expected_deltas.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // generous bound on the whole run
   initial begin
      #(4_000_000 * 12);
      $display("FAIL");
      $finish;
   end

endmodule
